// ===== hw/rtl/shg_pkg.sv =====
// Shared types, widths and state codes for the sorted hash group insert block.
`default_nettype none

package shg_pkg;

    localparam int GROUP_DEPTH_DEF = 1024;
    localparam int USER_LIMIT_DEF  = 1023;

    localparam int USER_W  = 10;
    localparam int HASH_W  = 32;
    localparam int SLOT_W  = 10;
    localparam int COUNT_W = 11;

    typedef struct packed {
        logic [USER_W-1:0]        user_number;
        logic signed [HASH_W-1:0] address_hash;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_W-1:0]  group_slot;
        logic               new_group;
        logic [USER_W-1:0]  previous_member;
        logic [COUNT_W-1:0] group_count;
        logic               table_full;
    } t_out_item;

    // One row of the sorted group table: key and chain head together.
    typedef struct packed {
        logic signed [HASH_W-1:0] key;
        logic [USER_W-1:0]        head;
    } t_group_entry;

    localparam int ENTRY_W = $bits(t_group_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CMP,
        S_SHIFT,
        S_INSERT
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/shg_ram.sv =====
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module shg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/shg_ctrl.sv =====
// Search, shift and insert sequencer for the sorted group table.
`default_nettype none

module shg_ctrl
    import shg_pkg::*;
#(
    parameter int GROUP_DEPTH = GROUP_DEPTH_DEF,
    parameter int USER_LIMIT  = USER_LIMIT_DEF,
    localparam int AW = $clog2(GROUP_DEPTH),
    localparam int UW = $clog2(USER_LIMIT + 1)
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire t_in_item     i_item,
    output logic              o_busy,
    output logic              o_done,
    output t_out_item         o_result,
    // group table port
    output logic              o_grp_we,
    output logic [AW-1:0]     o_grp_waddr,
    output logic [ENTRY_W-1:0] o_grp_wdata,
    output logic [AW-1:0]     o_grp_raddr,
    input  wire logic [ENTRY_W-1:0] i_grp_rdata,
    // member link port
    output logic              o_nm_we,
    output logic [UW-1:0]     o_nm_waddr,
    output logic [USER_W-1:0] o_nm_wdata
);

    localparam int CW = $clog2(GROUP_DEPTH + 1);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic                     r_done, n_done;
    logic                     r_wpend, n_wpend;
    t_out_item                r_res, n_res;
    logic [USER_W-1:0]        r_user, n_user;
    logic signed [HASH_W-1:0] r_key, n_key;
    logic [CW-1:0]            r_lo, n_lo;
    logic [CW-1:0]            r_hi, n_hi;
    logic [CW-1:0]            r_i, n_i;
    logic [AW-1:0]            r_mid, n_mid;
    logic [AW-1:0]            r_waddr, n_waddr;

    logic [CW:0]              mid_sum;
    logic [AW-1:0]            mid;
    t_group_entry             rd_entry;
    logic                     user_bad;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid      = AW'(mid_sum >> 1);
    assign rd_entry = t_group_entry'(i_grp_rdata);
    assign user_bad = (i_item.user_number == '0) ||
                      (32'(i_item.user_number) > 32'(USER_LIMIT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_wpend <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_wpend <= n_wpend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res   <= n_res;
        r_user  <= n_user;
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_mid   <= n_mid;
        r_waddr <= n_waddr;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_done  = 1'b0;
        n_wpend = r_wpend;
        n_res   = r_res;
        n_user  = r_user;
        n_key   = r_key;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_i     = r_i;
        n_mid   = r_mid;
        n_waddr = r_waddr;

        o_grp_we    = 1'b0;
        o_grp_waddr = r_mid;
        o_grp_wdata = ENTRY_W'({r_key, r_user});
        o_grp_raddr = r_mid;
        o_nm_we     = 1'b0;
        o_nm_waddr  = UW'(r_user);
        o_nm_wdata  = '0;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_user = i_item.user_number;
                    n_key  = i_item.address_hash;
                    if (user_bad) begin
                        n_done = 1'b1;
                        n_res  = '{group_slot: '0, new_group: 1'b0,
                                   previous_member: '0,
                                   group_count: COUNT_W'(r_count),
                                   table_full: 1'b0};
                    end else begin
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_state = S_PROBE;
                    end
                end
            end

            S_PROBE: begin
                if (r_lo < r_hi) begin
                    o_grp_raddr = mid;
                    n_mid       = mid;
                    n_state     = S_CMP;
                end else if (32'(r_count) >= 32'(GROUP_DEPTH)) begin
                    n_done  = 1'b1;
                    n_res   = '{group_slot: '0, new_group: 1'b0,
                                previous_member: '0,
                                group_count: COUNT_W'(r_count),
                                table_full: 1'b1};
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_count;
                    n_wpend = 1'b0;
                    n_state = S_SHIFT;
                end
            end

            S_CMP: begin
                if (rd_entry.key == r_key) begin
                    // Hit: the user becomes the new chain head.
                    o_grp_we    = 1'b1;
                    o_grp_waddr = r_mid;
                    o_nm_we     = 1'b1;
                    o_nm_wdata  = rd_entry.head;
                    n_done      = 1'b1;
                    n_res       = '{group_slot: SLOT_W'(r_mid), new_group: 1'b0,
                                    previous_member: rd_entry.head,
                                    group_count: COUNT_W'(r_count),
                                    table_full: 1'b0};
                    n_state     = S_IDLE;
                end else begin
                    if (r_key < rd_entry.key) begin
                        n_hi = CW'(r_mid);
                    end else begin
                        n_lo = CW'(r_mid) + 1'b1;
                    end
                    n_state = S_PROBE;
                end
            end

            S_SHIFT: begin
                // Read entry i-1 while the entry read last cycle lands one place up.
                if (r_wpend) begin
                    o_grp_we    = 1'b1;
                    o_grp_waddr = r_waddr;
                    o_grp_wdata = i_grp_rdata;
                end
                if (r_i > r_lo) begin
                    o_grp_raddr = AW'(r_i - 1'b1);
                    n_waddr     = AW'(r_i);
                    n_wpend     = 1'b1;
                    n_i         = r_i - 1'b1;
                end else begin
                    n_wpend = 1'b0;
                    n_state = S_INSERT;
                end
            end

            S_INSERT: begin
                o_grp_we    = 1'b1;
                o_grp_waddr = AW'(r_lo);
                o_nm_we     = 1'b1;
                n_count     = r_count + 1'b1;
                n_done      = 1'b1;
                n_res       = '{group_slot: SLOT_W'(r_lo), new_group: 1'b1,
                                previous_member: '0,
                                group_count: COUNT_W'(r_count + 1'b1),
                                table_full: 1'b0};
                n_state     = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(GROUP_DEPTH))
        else $error("group count exceeds table depth");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while an item is still in progress");

    a_new_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.new_group) |-> (r_count == CW'($past(r_count) + 1'b1)))
        else $error("new group reported without count increment");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.table_full) |->
            (!o_result.new_group && 32'(r_count) == 32'(GROUP_DEPTH)))
        else $error("table full reported on a table with room");

    a_shift_ports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT && o_grp_we && r_i > r_lo) |-> (o_grp_raddr != o_grp_waddr))
        else $error("shift reads and writes the same entry");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_hash_group_insert.sv =====
// Each item runs a binary search of probes; a hit ends there, a full table drops the item,
// and a new group then shifts each larger entry up one place and inserts the new one.
// Throughput: one item at a time; the entry-by-entry shift of the group table sets the bound.
// A user number of zero or above the limit returns a result in the cycle after acceptance.
// Synchronous active-low reset empties the table by clearing the group count, not the RAMs, and idles the sequencer.
// Results are strobed for one cycle and cannot be stalled.
`default_nettype none

module sorted_hash_group_insert
    import shg_pkg::*;
#(
    parameter int GROUP_DEPTH = GROUP_DEPTH_DEF,
    parameter int USER_LIMIT  = USER_LIMIT_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_in_item i_item,
    output logic          o_busy,
    output logic          o_done,
    output t_out_item     o_result
);

    localparam int AW = $clog2(GROUP_DEPTH);
    localparam int UW = $clog2(USER_LIMIT + 1);

    logic               grp_we;
    logic [AW-1:0]      grp_waddr;
    logic [ENTRY_W-1:0] grp_wdata;
    logic [AW-1:0]      grp_raddr;
    logic [ENTRY_W-1:0] grp_rdata;
    logic               nm_we;
    logic [UW-1:0]      nm_waddr;
    logic [USER_W-1:0]  nm_wdata;
    logic [USER_W-1:0]  nm_rdata;

    shg_ctrl #(
        .GROUP_DEPTH (GROUP_DEPTH),
        .USER_LIMIT  (USER_LIMIT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_grp_we    (grp_we),
        .o_grp_waddr (grp_waddr),
        .o_grp_wdata (grp_wdata),
        .o_grp_raddr (grp_raddr),
        .i_grp_rdata (grp_rdata),
        .o_nm_we     (nm_we),
        .o_nm_waddr  (nm_waddr),
        .o_nm_wdata  (nm_wdata)
    );

    shg_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (GROUP_DEPTH)
    ) u_group_ram (
        .i_clk   (i_clk),
        .i_we    (grp_we),
        .i_waddr (grp_waddr),
        .i_wdata (grp_wdata),
        .i_raddr (grp_raddr),
        .o_rdata (grp_rdata)
    );

    // Member links; read back on the same entry the sequencer writes.
    shg_ram #(
        .WIDTH (USER_W),
        .DEPTH (USER_LIMIT + 1)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (nm_we),
        .i_waddr (nm_waddr),
        .i_wdata (nm_wdata),
        .i_raddr (nm_waddr),
        .o_rdata (nm_rdata)
    );

`ifndef SYNTH
    a_link_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(nm_we, 2) && $past(nm_waddr) == $past(nm_waddr, 2) |->
            nm_rdata == $past(nm_wdata, 2))
        else $error("member link read back differs from value written");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted item neither in progress nor finished");

    a_link_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        nm_we |=> (o_done && !o_result.table_full))
        else $error("member link written without a matching result");
`endif

endmodule

`default_nettype wire
